// ===== sv/gbi_pkg.sv =====
// ----------------------------------------------------------------------------
// gbi_pkg
// shared types and constants for the bilinear grid interpolator
// ----------------------------------------------------------------------------
package gbi_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int MAX_COLS  = 2048;
    localparam int FRAC_BITS = 16;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int BANK_ROWS = MAX_ROWS / 2;
    localparam int BANK_COLS = MAX_COLS / 2;
    localparam int BANK_AW   = (ROW_W - 1) + (COL_W - 1);

    localparam int LAT_W = 24;
    localparam int LON_W = 25;
    localparam int IN_W  = 80;
    localparam int OUT_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic signed [LAT_W-1:0] DEG90  = 24'sd5898240;
    localparam logic signed [LON_W-1:0] DEG180 = 25'sd11796480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_LAT = 3'd0,
        REG_LAT_CPD   = 3'd1,
        REG_LON_CPD   = 3'd2,
        REG_ROWS      = 3'd3,
        REG_COLS      = 3'd4,
        REG_FILL      = 3'd5,
        REG_SCALE     = 3'd6
    } cfg_idx_t;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    typedef struct packed {
        logic signed [LAT_W-1:0] start_lat;
        logic [23:0]             lat_cpd;
        logic [23:0]             lon_cpd;
        logic [10:0]             rows;
        logic [11:0]             cols;
        logic [7:0]              fill;
        logic [15:0]             scale;
    } cfg_t;

    // neighbour read request plus cell write: one read address per bank, write bank select
    typedef struct packed {
        logic                wr;
        logic [1:0]          wbank;
        logic [BANK_AW-1:0]  waddr;
        logic [7:0]          wdata;
        logic                rd;
        logic [BANK_AW-1:0]  raddr0;
        logic [BANK_AW-1:0]  raddr1;
        logic [BANK_AW-1:0]  raddr2;
        logic [BANK_AW-1:0]  raddr3;
    } bank_req_t;

endpackage

// ===== sv/gbi_grid.sv =====
// ----------------------------------------------------------------------------
// gbi_grid
// four-bank grid store, banks split by row and column parity
// ----------------------------------------------------------------------------
module gbi_grid
    import gbi_pkg::*;
(
    input  logic          aclk,
    input  logic          en,
    input  bank_req_t     req,
    output logic [7:0]    rdata [4]
);

    logic [BANK_AW-1:0] raddr [4];

    assign raddr[0] = req.raddr0;
    assign raddr[1] = req.raddr1;
    assign raddr[2] = req.raddr2;
    assign raddr[3] = req.raddr3;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] mem [BANK_ROWS*BANK_COLS];
        logic [7:0] rd_reg;
        always_ff @(posedge aclk) begin
            if (req.wr && req.wbank == 2'(b)) begin
                mem[req.waddr] <= req.wdata;
            end
            if (en && req.rd) begin
                rd_reg <= mem[raddr[b]];
            end
        end
        assign rdata[b] = rd_reg;
    end

endmodule

// ===== sv/gbi_blend.sv =====
// ----------------------------------------------------------------------------
// gbi_blend
// fill replacement and bilinear blend, five register stages
// ----------------------------------------------------------------------------
module gbi_blend
    import gbi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic                 in_ok,
    input  logic [3:0]           in_okn,
    input  logic [7:0]           in_raw [4],
    input  logic [FRAC_BITS-1:0] in_fy,
    input  logic [FRAC_BITS-1:0] in_fx,
    input  logic [15:0]          scale,
    input  logic [7:0]           fill,
    output logic                 out_vld,
    output logic [23:0]          out_albedo,
    output logic                 out_good
);

    localparam int D_W = 24;

    // neighbour order: 0 (y,x) 1 (y+1,x) 2 (y,x+1) 3 (y+1,x+1)
    logic [4:0] vld_reg;

    // stage a: scale and validity
    logic [D_W-1:0] da_reg [4];
    logic [3:0]     oka_reg;
    logic           ga_reg;
    logic [FRAC_BITS-1:0] fya_reg, fxa_reg;
    // stage b: sum and count
    logic [D_W+1:0] sb_reg;
    logic [2:0]     nb_reg;
    logic [D_W-1:0] db_reg [4];
    logic [3:0]     okb_reg;
    logic           gb_reg;
    logic [FRAC_BITS-1:0] fyb_reg, fxb_reg;
    // stage c: mean and replacement
    logic [D_W-1:0] dc_reg [4];
    logic           gc_reg;
    logic [FRAC_BITS-1:0] fyc_reg, fxc_reg;
    // stage d: latitude blends
    logic [D_W-1:0] ad_reg, bd_reg;
    logic           gd_reg;
    logic [FRAC_BITS-1:0] fxd_reg;
    // stage e: longitude blend
    logic [D_W-1:0] re_reg;
    logic           ge_reg;

    logic [D_W-1:0] mean_next;
    logic [D_W+1:0] sum_next;
    logic [2:0]     cnt_next;

    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    function automatic logic [D_W-1:0] lerp(input logic [D_W-1:0] p,
                                            input logic [D_W-1:0] q,
                                            input logic [FRAC_BITS-1:0] f);
        logic [D_W+FRAC_BITS+1:0] acc;
        acc = (D_W+FRAC_BITS+2)'(p) * (D_W+FRAC_BITS+2)'(ONE - {1'b0, f})
            + (D_W+FRAC_BITS+2)'(q) * (D_W+FRAC_BITS+2)'(f);
        return D_W'(acc >> FRAC_BITS);
    endfunction

    always_comb begin
        sum_next = '0;
        cnt_next = '0;
        for (int i = 0; i < 4; i++) begin
            if (oka_reg[i]) begin
                sum_next = sum_next + (D_W+2)'(da_reg[i]);
                cnt_next = cnt_next + 3'd1;
            end
        end
    end

    // divide by one to four: shifts plus reciprocal for three
    always_comb begin
        logic [51:0] p3;
        p3 = 52'(sb_reg) * 52'(26'd44739243);
        case (nb_reg)
            3'd1:    mean_next = D_W'(sb_reg);
            3'd2:    mean_next = D_W'(sb_reg >> 1);
            3'd3:    mean_next = D_W'(p3 >> 27);
            3'd4:    mean_next = D_W'(sb_reg >> 2);
            default: mean_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                da_reg[i]  <= D_W'(in_raw[i]) * D_W'(scale);
                oka_reg[i] <= in_okn[i] && (in_raw[i] != fill);
            end
            ga_reg  <= in_ok;
            fya_reg <= in_fy;
            fxa_reg <= in_fx;

            sb_reg  <= sum_next;
            nb_reg  <= cnt_next;
            db_reg  <= da_reg;
            okb_reg <= oka_reg;
            gb_reg  <= ga_reg && (cnt_next != 3'd0);
            fyb_reg <= fya_reg;
            fxb_reg <= fxa_reg;

            for (int i = 0; i < 4; i++) begin
                dc_reg[i] <= okb_reg[i] ? db_reg[i] : mean_next;
            end
            gc_reg  <= gb_reg;
            fyc_reg <= fyb_reg;
            fxc_reg <= fxb_reg;

            ad_reg  <= lerp(dc_reg[0], dc_reg[1], fyc_reg);
            bd_reg  <= lerp(dc_reg[2], dc_reg[3], fyc_reg);
            gd_reg  <= gc_reg;
            fxd_reg <= fxc_reg;

            re_reg <= lerp(ad_reg, bd_reg, fxd_reg);
            ge_reg <= gd_reg;
        end
    end

    assign out_vld    = vld_reg[4];
    assign out_good   = ge_reg;
    assign out_albedo = ge_reg ? re_reg : '0;

endmodule

// ===== sv/gbi_locate.sv =====
// ----------------------------------------------------------------------------
// gbi_locate
// navigation check and grid position, three register stages
// ----------------------------------------------------------------------------
module gbi_locate
    import gbi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic                  in_op,
    input  logic [ROW_W-1:0]      in_row,
    input  logic [COL_W-1:0]      in_col,
    input  logic [7:0]            in_val,
    input  logic signed [LAT_W-1:0] in_lat,
    input  logic signed [LON_W-1:0] in_lon,
    input  cfg_t                  cfg,
    output bank_req_t             req,
    output logic                  out_vld,
    output logic                  out_ok,
    output logic [3:0]            out_okn,
    output logic [1:0]            out_par,
    output logic [FRAC_BITS-1:0]  out_fy,
    output logic [FRAC_BITS-1:0]  out_fx
);

    // stage 1: offsets and range check
    logic                 v1_reg, op1_reg, nav1_reg;
    logic signed [25:0]   dy1_reg;
    logic [24:0]          dx1_reg;
    logic [ROW_W-1:0]     r1_reg;
    logic [COL_W-1:0]     c1_reg;
    logic [7:0]           val1_reg;
    // stage 2: products
    logic                 v2_reg, op2_reg, nav2_reg;
    logic signed [50:0]   py2_reg;
    logic [49:0]          px2_reg;
    logic [ROW_W-1:0]     r2_reg;
    logic [COL_W-1:0]     c2_reg;
    logic [7:0]           val2_reg;
    // stage 3: flags and fractions, registered alongside the grid read
    logic                 v3_reg, ok3_reg;
    logic [3:0]           okn3_reg;
    logic [1:0]           par3_reg;
    logic [FRAC_BITS-1:0] fy3_reg, fx3_reg;

    logic signed [18:0] iy;
    logic [17:0]        ix;
    logic signed [19:0] iy1;
    logic [18:0]        ix1;
    logic [3:0]         okn;
    logic [ROW_W-1:0]   ry [2];
    logic [COL_W-1:0]   cx [2];
    logic [BANK_AW-1:0] ra [4];

    assign iy  = py2_reg[50:32];
    assign ix  = px2_reg[49:32];
    assign iy1 = 20'(iy) + 20'sd1;
    assign ix1 = 19'(ix) + 19'd1;

    always_comb begin
        logic ry0, ry1, cx0, cx1;
        ry0 = !iy[18] && ({1'b0, iy} < 20'(cfg.rows)) && (iy < 19'sd1024 * 19'sd1)
              && ({1'b0, iy} < 20'(MAX_ROWS));
        ry1 = !iy1[19] && (iy1 < 20'(cfg.rows)) && (iy1 < 20'(MAX_ROWS));
        cx0 = (19'(ix) < 19'(cfg.cols)) && (19'(ix) < 19'(MAX_COLS));
        cx1 = (ix1 < 19'(cfg.cols)) && (ix1 < 19'(MAX_COLS));
        okn = {ry1 && cx1, ry0 && cx1, ry1 && cx0, ry0 && cx0};
        ry[0] = ROW_W'(iy);
        ry[1] = ROW_W'(iy1);
        cx[0] = COL_W'(ix);
        cx[1] = COL_W'(ix1);
        // bank b = {col parity, row parity}
        for (int b = 0; b < 4; b++) begin
            logic [ROW_W-1:0] rr;
            logic [COL_W-1:0] cc;
            rr = (ry[0][0] == b[0]) ? ry[0] : ry[1];
            cc = (cx[0][0] == b[1]) ? cx[0] : cx[1];
            ra[b] = {rr[ROW_W-1:1], cc[COL_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && (op2_reg == OP_INTERP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg  <= in_op;
            nav1_reg <= (in_lat >= -DEG90) && (in_lat <= DEG90)
                        && (in_lon >= -DEG180) && (in_lon <= DEG180);
            dy1_reg  <= 26'(in_lat) - 26'(cfg.start_lat);
            dx1_reg  <= 25'(26'(in_lon) + 26'(DEG180));
            r1_reg   <= in_row;
            c1_reg   <= in_col;
            val1_reg <= in_val;

            op2_reg  <= op1_reg;
            nav2_reg <= nav1_reg;
            py2_reg  <= 51'(dy1_reg) * $signed({27'd0, cfg.lat_cpd});
            px2_reg  <= 50'(dx1_reg) * 50'(cfg.lon_cpd);
            r2_reg   <= r1_reg;
            c2_reg   <= c1_reg;
            val2_reg <= val1_reg;

            ok3_reg  <= nav2_reg;
            okn3_reg <= nav2_reg ? okn : 4'd0;
            par3_reg <= {cx[0][0], ry[0][0]};
            fy3_reg  <= py2_reg[31:32-FRAC_BITS];
            fx3_reg  <= px2_reg[31:32-FRAC_BITS];
        end
    end

    // reads happen in the cycle stage 2 advances; writes too
    always_comb begin
        req.wr     = en && v2_reg && (op2_reg == OP_LOAD);
        req.wbank  = {c2_reg[0], r2_reg[0]};
        req.waddr  = {r2_reg[ROW_W-1:1], c2_reg[COL_W-1:1]};
        req.wdata  = val2_reg;
        req.rd     = v2_reg && (op2_reg == OP_INTERP);
        req.raddr0 = ra[0];
        req.raddr1 = ra[1];
        req.raddr2 = ra[2];
        req.raddr3 = ra[3];
    end

    assign out_vld = v3_reg;
    assign out_ok  = ok3_reg;
    assign out_okn = okn3_reg;
    assign out_par = par3_reg;
    assign out_fy  = fy3_reg;
    assign out_fx  = fx3_reg;

endmodule

// ===== sv/grid_bilinear_interp_with_fill_core.sv =====
// ----------------------------------------------------------------------------
// grid_bilinear_interp_with_fill_core
// bilinear interpolation of a byte grid with missing-value fill
// ----------------------------------------------------------------------------
// usage
//   s_axis: one beat per item; tuser = operation (0 load cell, 1 interpolate)
//   load beats write one grid cell and give no result
//   interpolate beats give one m_axis beat: albedo Q8.16 and a good flag
//   cfg: register index and data; write while the block is idle (unenforced)
// throughput: one beat per cycle while m_axis does not stall
// pipeline: two locate stages, a third alongside the grid read, five blend
//   stages, then the output register that drives m_tvalid
// the grid sits in four banks by row and column parity so all four
//   neighbours come out of one read of the banks
// when m_axis stalls the pipe holds once the skid entry fills; the two-entry
//   skid at the output keeps s_tready high while a finished result waits
// reset clears valid bits and restores register defaults; grid content is
//   undefined until loaded
// ----------------------------------------------------------------------------
module grid_bilinear_interp_with_fill_core
    import gbi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cell_row[9:0] cell_col[20:10] cell_value[28:21] lat[52:29] lon[77:53]
    input  logic [IN_W-1:0]       s_tdata,
    // operation
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // albedo[23:0] valid_res[24]
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    cfg_t      cfg_reg;
    bank_req_t req;
    logic      en;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_lat <= -DEG90;
            cfg_reg.lat_cpd   <= 24'd1310720;
            cfg_reg.lon_cpd   <= 24'd1310720;
            cfg_reg.rows      <= 11'd1024;
            cfg_reg.cols      <= 12'd2048;
            cfg_reg.fill      <= 8'd255;
            cfg_reg.scale     <= 16'd66;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_START_LAT: cfg_reg.start_lat <= cfg_data;
                REG_LAT_CPD:   cfg_reg.lat_cpd   <= cfg_data;
                REG_LON_CPD:   cfg_reg.lon_cpd   <= cfg_data;
                REG_ROWS:      cfg_reg.rows      <= cfg_data[10:0];
                REG_COLS:      cfg_reg.cols      <= cfg_data[11:0];
                REG_FILL:      cfg_reg.fill      <= cfg_data[7:0];
                REG_SCALE:     cfg_reg.scale     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // front end
    logic                 loc_vld, loc_ok;
    logic [3:0]           loc_okn;
    logic [1:0]           loc_par;
    logic [FRAC_BITS-1:0] loc_fy, loc_fx;

    gbi_locate u_locate (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid && s_tready),
        .in_op   (s_tuser),
        .in_row  (s_tdata[9:0]),
        .in_col  (s_tdata[20:10]),
        .in_val  (s_tdata[28:21]),
        .in_lat  (s_tdata[52:29]),
        .in_lon  (s_tdata[77:53]),
        .cfg     (cfg_reg),
        .req     (req),
        .out_vld (loc_vld),
        .out_ok  (loc_ok),
        .out_okn (loc_okn),
        .out_par (loc_par),
        .out_fy  (loc_fy),
        .out_fx  (loc_fx)
    );

    // grid banks; bank read data lines up with locate stage 3
    logic [7:0] bank_q [4];
    gbi_grid u_grid (
        .aclk  (aclk),
        .en    (en),
        .req   (req),
        .rdata (bank_q)
    );

    // route banks back to neighbour order (y,x) (y+1,x) (y,x+1) (y+1,x+1)
    logic [7:0] nbr [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            nbr[i] = bank_q[2'(i) ^ loc_par];
        end
    end

    logic        bl_vld, bl_good;
    logic [23:0] bl_alb;

    gbi_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_vld     (loc_vld),
        .in_ok      (loc_ok),
        .in_okn     (loc_okn),
        .in_raw     (nbr),
        .in_fy      (loc_fy),
        .in_fx      (loc_fx),
        .scale      (cfg_reg.scale),
        .fill       (cfg_reg.fill),
        .out_vld    (bl_vld),
        .out_albedo (bl_alb),
        .out_good   (bl_good)
    );

    // output register plus skid entry
    logic        o_vld_reg, k_vld_reg;
    logic [24:0] o_dat_reg, k_dat_reg;

    // pipe moves when the skid entry is free
    assign en       = !k_vld_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
            k_vld_reg <= 1'b0;
        end else begin
            if (!o_vld_reg || m_tready) begin
                if (k_vld_reg) begin
                    o_vld_reg <= 1'b1;
                    o_dat_reg <= k_dat_reg;
                    k_vld_reg <= 1'b0;
                end else begin
                    o_vld_reg <= bl_vld;
                    o_dat_reg <= {bl_good, bl_alb};
                end
            end else if (bl_vld && en) begin
                k_vld_reg <= 1'b1;
                k_dat_reg <= {bl_good, bl_alb};
            end
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {7'd0, o_dat_reg};

endmodule

// ===== sv/gbi_checker.sv =====
// ----------------------------------------------------------------------------
// gbi_checker
// port-level checks for the grid interpolator
// ----------------------------------------------------------------------------
module gbi_checker
    import gbi_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[24] |-> m_tdata[23:0] == 24'd0)
        else $error("invalid result carries nonzero albedo");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_W-1:25] == '0)
        else $error("padding bits set");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind grid_bilinear_interp_with_fill_core gbi_checker u_gbi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/grid_bilinear_interp_with_fill_core_test.sv =====
// ----------------------------------------------------------------------------
// grid_bilinear_interp_with_fill_core_test
// self-checking bench for the bilinear grid interpolator with fill
// ----------------------------------------------------------------------------
// a directed table runs first on the reset settings, then several register
// settings each get a stream of random loads and lookups; every lookup
// result is compared with a typed-in value or an in-bench fixed-point model.
// cells a lookup would touch inside the grid are always loaded beforehand.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_bilinear_interp_with_fill_core_test;
    import gbi_pkg::*;

    localparam int  IDLE_LIMIT = 5000;   // cycles with no beat at all
    localparam int  DRAIN_WAIT = 16;     // pipe depth plus skid, with margin
    localparam int  LONG_HOLD  = 400;

    typedef struct {
        logic        op;
        logic [9:0]  row;
        logic [10:0] col;
        logic [7:0]  val;
        logic [23:0] lat;
        logic [24:0] lon;
        bit          typed;     // expected result typed in below
        logic [23:0] t_alb;
        logic        t_ok;
    } beat_t;

    typedef struct {
        logic [23:0] alb;
        logic        ok;
    } albedo_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    grid_bilinear_interp_with_fill_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // model of the block: register copy, grid content, pending results
    longint          g_start;
    longint unsigned g_lat_cpd, g_lon_cpd, g_rows, g_cols, g_fill, g_scale;
    logic [7:0]      grid_mem[int];
    bit              cell_loaded[int];   // cells already queued for loading
    albedo_t         albedo_q[$];

    int  err_cnt = 0;
    int  sent_cnt = 0;       // input beats accepted so far
    bit  burst = 1'b0;       // no idling on either side
    bit  hold_req = 1'b0;    // receiver holds off for a long stretch
    int  hold_cnt = 0;

    function automatic int cell_key(longint r, longint c);
        return int'(r) * MAX_COLS + int'(c);
    endfunction

    function automatic bit in_grid(longint r, longint c);
        return r >= 0 && r < longint'(g_rows) && r < MAX_ROWS &&
               c >= 0 && c < longint'(g_cols) && c < MAX_COLS;
    endfunction

    // floor index of the top-left neighbour plus fractions
    function automatic void locate(input logic [23:0] lat_f, input logic [24:0] lon_f,
                                   output longint iy, output longint ix,
                                   output longint unsigned fy, output longint unsigned fx);
        longint py, px;
        py = (longint'($signed(lat_f)) - g_start) * longint'(g_lat_cpd);
        px = (longint'($signed(lon_f)) + longint'(DEG180)) * longint'(g_lon_cpd);
        iy = py >>> 32;
        ix = px >>> 32;
        fy = longint'(unsigned'(py[31:16]));
        fx = longint'(unsigned'(px[31:16]));
    endfunction

    function automatic albedo_t blend_albedo(logic [23:0] lat_f, logic [24:0] lon_f);
        albedo_t         res;
        longint          lat, lon, iy, ix, r, c;
        longint unsigned fy, fx, one, sum, a, b, raw;
        longint unsigned d[2][2];
        bit              good[2][2];
        int              n;
        res.alb = '0;
        res.ok  = 1'b0;
        lat = longint'($signed(lat_f));
        lon = longint'($signed(lon_f));
        // bad navigation
        if (lat < -longint'(DEG90) || lat > longint'(DEG90) ||
            lon < -longint'(DEG180) || lon > longint'(DEG180))
            return res;
        locate(lat_f, lon_f, iy, ix, fy, fx);
        sum = 0;
        n = 0;
        for (int ip = 0; ip < 2; ip++)
            for (int il = 0; il < 2; il++) begin
                r = iy + il;
                c = ix + ip;
                raw = 0;
                good[ip][il] = 1'b0;
                if (in_grid(r, c) && grid_mem.exists(cell_key(r, c))) begin
                    raw = grid_mem[cell_key(r, c)];
                    good[ip][il] = (raw != g_fill);
                end
                if (!good[ip][il]) raw = 0;
                d[ip][il] = raw * g_scale;
                if (good[ip][il]) begin
                    sum += d[ip][il];
                    n++;
                end
            end
        // all four neighbours missing
        if (n == 0) return res;
        sum = sum / longint'(n);
        for (int ip = 0; ip < 2; ip++)
            for (int il = 0; il < 2; il++)
                if (!good[ip][il]) d[ip][il] = sum;
        one = 64'd1 << FRAC_BITS;
        a = (d[0][0] * (one - fy) + d[0][1] * fy) >> FRAC_BITS;
        b = (d[1][0] * (one - fy) + d[1][1] * fy) >> FRAC_BITS;
        res.alb = 24'((a * (one - fx) + b * fx) >> FRAC_BITS);
        res.ok  = 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic push_beat(beat_t it);
        albedo_t e;
        int      gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {2'b00, it.lon, it.lat, it.val, it.col, it.row};
        do @(posedge aclk); while (!s_tready);
        // beat taken at this edge
        sent_cnt++;
        if (it.op == OP_LOAD) begin
            grid_mem[cell_key(it.row, it.col)] = it.val;
        end else begin
            if (it.typed) begin
                e.alb = it.t_alb;
                e.ok  = it.t_ok;
            end else begin
                e = blend_albedo(it.lat, it.lon);
            end
            albedo_q.push_back(e);
        end
    endtask

    function automatic logic [7:0] rand_cell_value();
        return ($urandom_range(0, 4) == 0) ? 8'(g_fill) : 8'($urandom);
    endfunction

    task automatic load_cell(longint r, longint c, logic [7:0] v);
        beat_t it;
        it.op = OP_LOAD;
        it.row = 10'(r);
        it.col = 11'(c);
        it.val = v;
        it.lat = 24'($urandom);
        it.lon = 25'($urandom);
        it.typed = 1'b0;
        it.t_alb = '0;
        it.t_ok = 1'b0;
        cell_loaded[cell_key(r, c)] = 1'b1;
        push_beat(it);
    endtask

    // a lookup never touches a grid cell that was never loaded
    task automatic lookup(beat_t it);
        longint          iy, ix;
        longint unsigned fy, fx;
        locate(it.lat, it.lon, iy, ix, fy, fx);
        for (int ip = 0; ip < 2; ip++)
            for (int il = 0; il < 2; il++)
                if (in_grid(iy + il, ix + ip) &&
                    !cell_loaded.exists(cell_key(iy + il, ix + ip)))
                    load_cell(iy + il, ix + ip, rand_cell_value());
        push_beat(it);
    endtask

    task automatic send_any(beat_t it);
        if (it.op == OP_LOAD) load_cell(it.row, it.col, it.val);
        else lookup(it);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (albedo_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_START_LAT: g_start   = longint'($signed(v));
            REG_LAT_CPD:   g_lat_cpd = v;
            REG_LON_CPD:   g_lon_cpd = v;
            REG_ROWS:      g_rows    = v[10:0];
            REG_COLS:      g_cols    = v[11:0];
            REG_FILL:      g_fill    = v[7:0];
            REG_SCALE:     g_scale   = v[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    function automatic longint pick(longint lo, longint hi);
        if (hi < lo) hi = lo;
        return lo + longint'({32'd0, $urandom} % longint'(hi - lo + 1));
    endfunction

    function automatic longint clip(longint v, longint lim);
        return (v < -lim) ? -lim : ((v > lim) ? lim : v);
    endfunction

    // random cell load, or a lookup near the active grid or anywhere
    task automatic random_step();
        beat_t  it;
        int     k;
        longint span, lo, hi;
        k = $urandom_range(0, 99);
        it.typed = 1'b0;
        it.t_alb = '0;
        it.t_ok = 1'b0;
        it.row = 10'($urandom);
        it.col = 11'($urandom);
        it.val = rand_cell_value();
        it.lat = 24'($urandom);
        it.lon = 25'($urandom);
        if (k < 25) begin
            // overwrite a cell inside the active grid
            it.op  = OP_LOAD;
            it.row = 10'($urandom_range(0, int'((g_rows > 1024) ? 1023 : g_rows - 1)));
            it.col = 11'($urandom_range(0, int'((g_cols > 2048) ? 2047 : g_cols - 1)));
            load_cell(it.row, it.col, it.val);
        end else if (k < 30) begin
            // load anywhere in the store
            it.op = OP_LOAD;
            load_cell(it.row, it.col, it.val);
        end else begin
            it.op = OP_INTERP;
            if (k < 85) begin
                span = (longint'(1) << 32) / longint'(g_lat_cpd);
                lo = clip(g_start - span, DEG90);
                hi = clip(g_start + longint'(g_rows + 1) * span, DEG90);
                it.lat = 24'(pick(lo, hi));
                span = (longint'(1) << 32) / longint'(g_lon_cpd);
                lo = -longint'(DEG180);
                hi = clip(lo + longint'(g_cols + 1) * span, DEG180);
                it.lon = 25'(pick(lo, hi));
            end else if (k < 93) begin
                it.lat = 24'(pick(-longint'(DEG90), DEG90));
                it.lon = 25'(pick(-longint'(DEG180), DEG180));
            end
            lookup(it);
        end
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    initial begin : result_side
        int      stall;
        albedo_t e;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                stall = 0;
                m_tready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < LONG_HOLD) begin
                    @(posedge aclk);
                    hold_cnt++;
                end
                hold_req = 1'b0;
            end else begin
                stall = burst ? 0 : $urandom_range(0, 15);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (albedo_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result beat: albedo %0d good %0b",
                             m_tdata[23:0], m_tdata[24]);
            end else begin
                e = albedo_q.pop_front();
                if (m_tdata[23:0] !== e.alb || m_tdata[24] !== e.ok) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("result mismatch: albedo %0d good %0b, expected %0d good %0b",
                                 m_tdata[23:0], m_tdata[24], e.alb, e.ok);
                end
            end
        end
    end

    // watchdog on any beat moving
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    beat_t dir_tab[$];

    task automatic dir_row(logic op, int r, int c, int v, int lat, int lon,
                           bit typed, int alb, logic ok);
        beat_t it;
        it.op = op;
        it.row = 10'(r);
        it.col = 11'(c);
        it.val = 8'(v);
        it.lat = 24'(lat);
        it.lon = 25'(lon);
        it.typed = typed;
        it.t_alb = 24'(alb);
        it.t_ok = ok;
        dir_tab.push_back(it);
    endtask

    task automatic set_regs(longint st, longint lcpd, longint ocpd, longint rows,
                            longint cols, longint fill, longint scl);
        wait_drained();
        write_reg(REG_START_LAT, 24'(st));
        write_reg(REG_LAT_CPD, 24'(lcpd));
        write_reg(REG_LON_CPD, 24'(ocpd));
        write_reg(REG_ROWS, 24'(rows));
        write_reg(REG_COLS, 24'(cols));
        write_reg(REG_FILL, 24'(fill));
        write_reg(REG_SCALE, 24'(scl));
    endtask

    initial begin : stimulus
        int ph_end;
        // reset register values
        g_start = -longint'(DEG90);
        g_lat_cpd = 1310720;
        g_lon_cpd = 1310720;
        g_rows = 1024;
        g_cols = 2048;
        g_fill = 255;
        g_scale = 66;

        // corner cell block all fill
        dir_row(OP_LOAD, 0, 0, 255, 0, 0, 0, 0, 0);
        dir_row(OP_LOAD, 1, 0, 255, 0, 0, 0, 0, 0);
        dir_row(OP_LOAD, 0, 1, 255, 0, 0, 0, 0, 0);
        dir_row(OP_LOAD, 1, 1, 255, 0, 0, 0, 0, 0);
        dir_row(OP_INTERP, 0, 0, 0, -5898240, -11796480, 1, 0, 0);
        // one valid neighbour, mean fills the rest
        dir_row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_row(OP_INTERP, 1023, 2047, 255, -5898240, -11796480, 0, 0, 0);
        dir_row(OP_LOAD, 1023, 2047, 254, 0, 0, 0, 0, 0);
        // bad navigation at the field extremes and just past the limits
        dir_row(OP_INTERP, 0, 0, 0, 8388607, 0, 1, 0, 0);
        dir_row(OP_INTERP, 0, 0, 0, -8388608, 0, 1, 0, 0);
        dir_row(OP_INTERP, 0, 0, 0, 0, 16777215, 1, 0, 0);
        dir_row(OP_INTERP, 0, 0, 0, 0, -16777216, 1, 0, 0);
        dir_row(OP_INTERP, 0, 0, 0, 5898241, 0, 1, 0, 0);
        dir_row(OP_INTERP, 0, 0, 0, 0, 11796481, 1, 0, 0);
        dir_row(OP_INTERP, 0, 0, 0, -5898241, -11796481, 1, 0, 0);
        // exact limits: rows and columns beyond the grid
        dir_row(OP_INTERP, 0, 0, 0, 5898240, 11796480, 0, 0, 0);
        // last row and column, neighbours past the edge
        dir_row(OP_INTERP, 0, 0, 0, -5898240 + 3352167, -11796480 + 6707610, 0, 0, 0);
        dir_row(OP_LOAD, 1023, 2047, 255, 0, 0, 0, 0, 0);
        dir_row(OP_INTERP, 0, 0, 0, -5898240 + 3352167, -11796480 + 6707610, 1, 0, 0);
        dir_row(OP_LOAD, 5, 7, 1, 0, 0, 0, 0, 0);
        dir_row(OP_INTERP, 0, 0, 0, -5898240 + 16384, -11796480 + 22000, 0, 0, 0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) send_any(dir_tab[i]);

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_regs(-5898240, 1310720, 1310720, 1024, 2048, 255, 66);
                1: set_regs(0, 65536, 131072, 6, 10, 0, 65535);
                2: set_regs(5898240, 16777215, 16777215, 1, 2, 128, 0);
                3: set_regs(-5898240, 1, 1, 1024, 2048, 255, 12345);
                4: set_regs(-1000000, 300000, 2000000, 64, 100,
                            $urandom_range(0, 255), $urandom_range(0, 65535));
                default: set_regs(pick(-longint'(DEG90), DEG90), $urandom_range(1, 16777215),
                                  $urandom_range(1, 16777215), $urandom_range(2, 40),
                                  $urandom_range(2, 60), $urandom_range(0, 255),
                                  $urandom_range(0, 65535));
            endcase
            // each setting gets about the same number of input beats
            ph_end = sent_cnt + 261;
            for (int i = 0; sent_cnt < ph_end; i++) begin
                if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
                // sender pauses until the pipe is empty
                if (ph == 0 && i == 40) wait_drained();
                // receiver holds off while the sender streams
                if (ph == 1 && i == 40) begin
                    hold_req = 1'b1;
                    burst = 1'b1;
                end
                random_step();
            end
            burst = 1'b0;
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_cnt == 0 && albedo_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/gbi_pkg.sv
sv/gbi_grid.sv
sv/gbi_blend.sv
sv/gbi_locate.sv
sv/grid_bilinear_interp_with_fill_core.sv
sv/gbi_checker.sv
dv/grid_bilinear_interp_with_fill_core_test.sv
